@@ hw/rtl/cti_pkg.sv @@
// Shared types and widths for the count-to-temperature interpolator.
// No dependencies; used by cti_muldiv and the top level.
package cti_pkg;

    localparam int CNT_W   = 16;               // raw count width, signed
    localparam int TEMP_W  = 16;               // Q9.7 kelvin, unsigned
    localparam int IDX_W   = 8;                // load index width
    localparam int CFG_W   = 9;                // entries_in_use width
    localparam int ENTRY_W = CNT_W + TEMP_W;   // one packed table entry

    // Serial multiply/divide operand width and step count
    localparam int                MD_W      = 16;
    localparam int                STEP_W    = $clog2(MD_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MD_W - 1);

    // Operands handed to the serial arithmetic unit
    typedef struct packed {
        logic [MD_W-1:0] mcand;     // |T[k] - T[k-1]|
        logic [MD_W-1:0] mult;      // C[k] - sample
        logic [MD_W-1:0] divisor;   // C[k] - C[k-1]
    } t_md_req;

endpackage

@@ hw/rtl/count_to_temperature_lut_interp_top.sv @@
// Count-to-temperature converter: calibration table search plus linear interpolation.
// Depends on cti_pkg and cti_muldiv; the table lives in one internal memory, kept over reset.
// Load: written at accept, no result. Convert on an empty table: strobe in the cycle after accept.
// Otherwise scan one entry per cycle; a hit on the first entry or a miss ends with the strobe,
// while a hit inside a segment first runs the serial multiply and then the divide.
// Busy drops as the strobe rises. Sync active-low reset idles and clears entries_in_use.
module count_to_temperature_lut_interp_top
    import cti_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // command channel
    input  logic              start,
    output logic              busy,
    input  logic              i_mode,
    input  logic [IDX_W-1:0]  i_entry_index,
    input  logic [CNT_W-1:0]  i_entry_count,
    input  logic [TEMP_W-1:0] i_entry_temp,
    input  logic [CNT_W-1:0]  i_sample,
    // configuration: entries_in_use
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    // result channel, one-cycle strobe, no backpressure
    output logic              o_strobe,
    output logic [TEMP_W-1:0] o_temperature,
    output logic              o_valid_res
);

    localparam int AW = $clog2(TABLE_DEPTH);       // table address width
    localparam int NW = $clog2(TABLE_DEPTH + 1);   // entry count width
    localparam int XW = AW + IDX_W;                // index compare width

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_CONV = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_ARITH = 3'b100
    } t_state;

    // Control registers
    t_state                   r_state;
    logic [NW-1:0]            r_n;          // entries searched, clamped to depth
    logic                     r_strobe;

    // Payload registers
    logic [NW-1:0]            r_k;          // index of entry now in r_rd_data
    logic signed [CNT_W-1:0]  r_sample;
    logic [ENTRY_W-1:0]       r_prev;       // entry k-1 while scanning
    logic [TEMP_W-1:0]        r_tk;
    logic                     r_neg;        // temperature falls across the segment
    logic [TEMP_W-1:0]        r_temp;
    logic                     r_valid;

    // Calibration table: {count, temperature} per entry
    logic [ENTRY_W-1:0]       r_mem [TABLE_DEPTH];
    logic [ENTRY_W-1:0]       r_rd_data;

    // Handshake and table access
    logic                     accept;
    logic                     conv_acc;
    logic [XW-1:0]            idx_ext;
    logic                     wr_en;
    logic                     rd_en;
    logic [AW-1:0]            rd_addr;

    // Scan decode
    logic signed [CNT_W-1:0]  cur_cnt;
    logic [TEMP_W-1:0]        cur_tmp;
    logic signed [CNT_W-1:0]  prev_cnt;
    logic [TEMP_W-1:0]        prev_tmp;
    logic [NW-1:0]            k_next;
    logic                     scan;
    logic                     first;
    logic                     last;
    logic                     s_lt;
    logic                     s_eq;
    logic                     s_le;
    logic                     empty_hit;
    logic                     hit_first;
    logic                     miss;
    logic                     advance;
    logic                     launch;
    logic                     arith_done;

    // Segment arithmetic
    logic [TEMP_W:0]          dt;
    logic [TEMP_W:0]          dt_abs;
    logic [CNT_W:0]           gap;
    logic [CNT_W:0]           den;
    t_md_req                  md_req;
    logic                     md_done;
    logic [MD_W-1:0]          md_quot;
    logic [TEMP_W-1:0]        interp;

    assign busy     = (r_state != ST_IDLE);
    assign accept   = start && !busy;
    assign conv_acc = accept && (i_mode == MODE_CONV);

    // Loads beyond the table depth are dropped
    assign idx_ext = XW'(i_entry_index);
    assign wr_en   = accept && (i_mode == MODE_LOAD) && (idx_ext < XW'(TABLE_DEPTH));

    // Entry 0 is fetched at accept; afterwards prefetch k+1 while k is examined
    assign k_next  = r_k + 1'b1;
    assign rd_en   = (conv_acc && (r_n != '0)) || (scan && (k_next < r_n));
    assign rd_addr = scan ? k_next[AW-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[idx_ext[AW-1:0]] <= {i_entry_count, i_entry_temp};
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign cur_cnt  = signed'(r_rd_data[ENTRY_W-1:TEMP_W]);
    assign cur_tmp  = r_rd_data[TEMP_W-1:0];
    assign prev_cnt = signed'(r_prev[ENTRY_W-1:TEMP_W]);
    assign prev_tmp = r_prev[TEMP_W-1:0];

    assign scan  = (r_state == ST_SCAN);
    assign first = (r_k == '0);
    assign last  = (k_next == r_n);
    assign s_lt  = (r_sample < cur_cnt);
    assign s_eq  = (r_sample == cur_cnt);
    assign s_le  = s_lt || s_eq;

    // First entry: below is invalid, equal returns its temperature.
    // Later entries: the first count at or above the sample closes the segment.
    assign empty_hit  = conv_acc && (r_n == '0);
    assign hit_first  = scan && first && s_eq;
    assign launch     = scan && !first && s_le;
    assign miss       = scan && ((first && s_lt) || (!s_le && last));
    assign advance    = scan && !s_le && !last;
    assign arith_done = (r_state == ST_ARITH) && md_done;

    // Since C[k-1] < sample <= C[k], the divisor is positive, the quotient stays
    // below |T[k]-T[k-1]| and the result lies between the two temperatures.
    assign dt     = {1'b0, cur_tmp} - {1'b0, prev_tmp};
    assign dt_abs = dt[TEMP_W] ? ((TEMP_W+1)'(0) - dt) : dt;
    assign gap    = {cur_cnt[CNT_W-1], cur_cnt} - {r_sample[CNT_W-1], r_sample};
    assign den    = {cur_cnt[CNT_W-1], cur_cnt} - {prev_cnt[CNT_W-1], prev_cnt};

    assign md_req.mcand   = dt_abs[MD_W-1:0];
    assign md_req.mult    = gap[MD_W-1:0];
    assign md_req.divisor = den[MD_W-1:0];

    cti_muldiv u_md (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (launch),
        .i_req   (md_req),
        .o_done  (md_done),
        .o_quot  (md_quot)
    );

    // Correction is subtracted from T[k]; a falling segment adds it back
    assign interp = r_neg ? (r_tk + md_quot) : (r_tk - md_quot);

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_n      <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= empty_hit || hit_first || miss || arith_done;
            if (i_cfg_we) begin
                if (32'(i_cfg_wdata) > 32'(TABLE_DEPTH)) begin
                    r_n <= NW'(TABLE_DEPTH);
                end else begin
                    r_n <= NW'(i_cfg_wdata);
                end
            end
            case (r_state)
                ST_IDLE: begin
                    if (conv_acc && (r_n != '0)) begin
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (launch) begin
                        r_state <= ST_ARITH;
                    end else if (hit_first || miss) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_ARITH: begin
                    if (md_done) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (conv_acc) begin
            r_sample <= signed'(i_sample);
            r_k      <= '0;
        end
        if (advance) begin
            r_k    <= k_next;
            r_prev <= r_rd_data;
        end
        if (launch) begin
            r_tk  <= cur_tmp;
            r_neg <= dt[TEMP_W];
        end
        if (empty_hit || miss) begin
            r_temp  <= '0;
            r_valid <= 1'b0;
        end else if (hit_first) begin
            r_temp  <= cur_tmp;
            r_valid <= 1'b1;
        end else if (arith_done) begin
            r_temp  <= interp;
            r_valid <= 1'b1;
        end
    end

    assign o_strobe      = r_strobe;
    assign o_temperature = r_temp;
    assign o_valid_res   = r_valid;

    // A result leaves the block idle, so the next command can be taken during the strobe
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> (r_state == ST_IDLE))
        else $error("result strobe while the block is busy");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && !r_valid) |-> (r_temp == '0))
        else $error("invalid result carries a nonzero temperature");

    a_scan_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) == ST_SCAN && r_state == ST_IDLE) |-> r_strobe)
        else $error("scan ended without a result");

    a_arith_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        arith_done |=> (r_strobe && r_valid && r_state == ST_IDLE))
        else $error("interpolation finished without a valid result");

endmodule

@@ hw/rtl/cti_muldiv.sv @@
// Bit-serial unsigned multiply followed by restoring divide: (mcand*mult)/divisor.
// Depends on cti_pkg. One bit per cycle in each phase, multiply then divide.
module cti_muldiv
    import cti_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  t_md_req         i_req,
    output logic            o_done,
    output logic [MD_W-1:0] o_quot
);

    typedef enum logic [2:0] {
        MD_IDLE = 3'b001,
        MD_MUL  = 3'b010,
        MD_DIV  = 3'b100
    } t_md_state;

    t_md_state         r_state;
    logic [STEP_W-1:0] r_step;
    logic              r_done;
    logic [MD_W:0]     r_hi;      // product high half, then remainder
    logic [MD_W-1:0]   r_lo;      // multiplier / product low, then quotient
    logic [MD_W-1:0]   r_mcand;
    logic [MD_W-1:0]   r_div;

    logic [MD_W:0]     mul_sum;
    logic [MD_W:0]     div_trial;
    logic              div_ge;

    assign mul_sum   = r_hi + (r_lo[0] ? {1'b0, r_mcand} : '0);
    assign div_trial = {r_hi[MD_W-1:0], r_lo[MD_W-1]};
    assign div_ge    = (div_trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MD_IDLE;
            r_step  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                MD_IDLE: begin
                    if (i_start) begin
                        r_state <= MD_MUL;
                        r_step  <= '0;
                    end
                end
                MD_MUL: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == LAST_STEP) begin
                        r_state <= MD_DIV;
                        r_step  <= '0;
                    end
                end
                MD_DIV: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == LAST_STEP) begin
                        r_state <= MD_IDLE;
                        r_step  <= '0;
                        r_done  <= 1'b1;
                    end
                end
                default: begin
                    r_state <= MD_IDLE;
                end
            endcase
        end
    end

    // Datapath: shift-add multiply, then shift-subtract divide on the same pair
    always_ff @(posedge i_clk) begin
        case (r_state)
            MD_IDLE: begin
                if (i_start) begin
                    r_hi    <= '0;
                    r_lo    <= i_req.mult;
                    r_mcand <= i_req.mcand;
                    r_div   <= i_req.divisor;
                end
            end
            MD_MUL: begin
                r_hi <= {1'b0, mul_sum[MD_W:1]};
                r_lo <= {mul_sum[0], r_lo[MD_W-1:1]};
            end
            MD_DIV: begin
                r_hi <= div_ge ? (div_trial - {1'b0, r_div}) : div_trial;
                r_lo <= {r_lo[MD_W-2:0], div_ge};
            end
            default: begin
                r_hi <= r_hi;
            end
        endcase
    end

    assign o_done = r_done;
    assign o_quot = r_lo;

endmodule

@@ dv/tb.sv @@
// Self-checking bench for count_to_temperature_lut_interp_top: calibration loads and
// conversions, random idle gaps, expected temperatures from an in-bench table model.
// Depends on cti_pkg and the RTL top level only.
module tb
    import cti_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int   TABLE_DEPTH  = 256;
    localparam int   CYCLE_LIMIT  = 2_000_000;
    localparam int   DRAIN_CYCLES = 300;   // wait for stray results after the final drain
    localparam int   CFG_SETTLE   = 8;     // a trailing load is written at its accept
    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_CONVERT = 1'b1;

    // One command transaction, one field per input port
    typedef struct packed {
        logic              mode;
        logic [IDX_W-1:0]  index;
        logic [CNT_W-1:0]  count;
        logic [TEMP_W-1:0] temp;
        logic [CNT_W-1:0]  sample;
    } t_sensor_cmd;

    // One result transaction
    typedef struct packed {
        logic [TEMP_W-1:0] temperature;
        logic              valid_res;
    } t_temp_result;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              start         = 1'b0;
    logic              busy;
    logic              i_mode        = MODE_LOAD;
    logic [IDX_W-1:0]  i_entry_index = '0;
    logic [CNT_W-1:0]  i_entry_count = '0;
    logic [TEMP_W-1:0] i_entry_temp  = '0;
    logic [CNT_W-1:0]  i_sample      = '0;
    logic              i_cfg_we      = 1'b0;
    logic [CFG_W-1:0]  i_cfg_wdata   = '0;
    logic              o_strobe;
    logic [TEMP_W-1:0] o_temperature;
    logic              o_valid_res;

    // Bench copy of the calibration table and the entries_in_use register,
    // updated in transaction order as the block accepts commands
    logic signed [CNT_W-1:0] cal_count [TABLE_DEPTH];
    logic [TEMP_W-1:0]       cal_temp  [TABLE_DEPTH];
    logic [CFG_W-1:0]        active_entries = '0;

    // Stimulus-side view of the table: what it will hold once every queued load lands.
    // Used to aim samples at entries and to keep reads off unwritten entries.
    int plan_count   [TABLE_DEPTH];
    bit plan_written [TABLE_DEPTH];

    t_sensor_cmd  pending_cmds[$];
    t_temp_result expected_temps[$];

    t_sensor_cmd cur_cmd;
    int          idle_left  = 0;
    int          gap_roll;
    bit          no_idle    = 1'b0;
    int          fail_count = 0;
    int          cycle_count = 0;

    count_to_temperature_lut_interp_top #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_mode        (i_mode),
        .i_entry_index (i_entry_index),
        .i_entry_count (i_entry_count),
        .i_entry_temp  (i_entry_temp),
        .i_sample      (i_sample),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_strobe      (o_strobe),
        .o_temperature (o_temperature),
        .o_valid_res   (o_valid_res)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Find the first entry at or above the sample and interpolate back toward the
    // entry before it. Division on longint truncates toward zero.
    function automatic t_temp_result interpolate_temp(logic signed [CNT_W-1:0] s);
        t_temp_result res;
        int           n;
        longint       ck, cp, tk, tp, den, r;
        res = '0;
        n   = (active_entries > TABLE_DEPTH) ? TABLE_DEPTH : int'(active_entries);
        if (n > 0 && s >= cal_count[0]) begin
            if (s == cal_count[0]) begin
                res.temperature = cal_temp[0];
                res.valid_res   = 1'b1;
            end else begin
                for (int k = 1; k < n && !res.valid_res; k++) begin
                    if (s <= cal_count[k]) begin
                        ck  = longint'(cal_count[k]);
                        cp  = longint'(cal_count[k-1]);
                        tk  = longint'(cal_temp[k]);
                        tp  = longint'(cal_temp[k-1]);
                        den = ck - cp;
                        // equal adjacent counts: take this entry's temperature
                        if (den == 0)
                            r = tk;
                        else
                            r = tk - ((tk - tp) * (ck - longint'(s))) / den;
                        if (r < 0)
                            r = 0;
                        if (r > 65535)
                            r = 65535;
                        res.temperature = r[TEMP_W-1:0];
                        res.valid_res   = 1'b1;
                    end
                end
            end
        end
        return res;
    endfunction

    function automatic int rand_count();
        return int'($urandom_range(65535)) - 32768;
    endfunction

    // Lean on the temperature extremes now and then
    function automatic int rand_temp();
        int roll;
        roll = $urandom_range(9);
        if (roll == 0)
            return 0;
        if (roll == 1)
            return 65535;
        return int'($urandom_range(65535));
    endfunction

    // Aim a sample at the interesting spots of the planned table: below the first
    // count, above the last, exactly on an entry, inside a segment, or at random.
    function automatic int pick_sample(int n_eff);
        int kind, k, lo, hi, s;
        kind = $urandom_range(9);
        if (n_eff < 2 && kind >= 4 && kind <= 7)
            kind = 2;
        if (n_eff == 0)
            kind = 8;
        case (kind)
            0: begin
                lo = plan_count[0];
                s  = (lo > -32768) ? -32768 + int'($urandom_range(lo + 32767)) : lo;
            end
            1: begin
                hi = plan_count[n_eff-1];
                s  = (hi < 32767) ? hi + 1 + int'($urandom_range(32766 - hi)) : hi;
            end
            2, 3: begin
                s = plan_count[$urandom_range(n_eff - 1)];
            end
            4, 5, 6, 7: begin
                k  = $urandom_range(n_eff - 1, 1);
                lo = plan_count[k-1];
                hi = plan_count[k];
                s  = (hi > lo) ? lo + 1 + int'($urandom_range(hi - lo - 1)) : hi;
            end
            default: begin
                s = rand_count();
            end
        endcase
        return s;
    endfunction

    task automatic push_load(int idx, int cnt, int tmp);
        t_sensor_cmd cmd;
        cmd.mode   = MODE_LOAD;
        cmd.index  = idx[IDX_W-1:0];
        cmd.count  = cnt[CNT_W-1:0];
        cmd.temp   = tmp[TEMP_W-1:0];
        cmd.sample = CNT_W'($urandom);     // ignored by a load, toggle it anyway
        plan_count[idx]   = cnt;
        plan_written[idx] = 1'b1;
        pending_cmds.push_back(cmd);
    endtask

    task automatic push_convert(int s);
        t_sensor_cmd cmd;
        cmd.mode   = MODE_CONVERT;
        cmd.index  = IDX_W'($urandom);     // load fields are don't-care here
        cmd.count  = CNT_W'($urandom);
        cmd.temp   = TEMP_W'($urandom);
        cmd.sample = s[CNT_W-1:0];
        pending_cmds.push_back(cmd);
    endtask

    // Hold the generator until every queued command is accepted, every expected
    // result has come back and the block reports idle
    task automatic wait_drain();
        do
            @(posedge i_clk);
        while (pending_cmds.size() != 0 || start || busy || expected_temps.size() != 0);
    endtask

    // Write entries_in_use while the block is idle
    task automatic set_entries(int value);
        wait_drain();
        repeat (CFG_SETTLE) @(posedge i_clk);
        i_cfg_we       <= 1'b1;
        i_cfg_wdata    <= value[CFG_W-1:0];
        active_entries  = value[CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we       <= 1'b0;
    endtask

    // Load entries 0..n_eff-1, sorted with random content in most calls
    task automatic build_table(int n_eff, bit sorted);
        int vals [TABLE_DEPTH];
        int i, j, k, tmp;
        for (i = 0; i < n_eff; i++)
            vals[i] = rand_count();
        if (sorted) begin
            for (i = 1; i < n_eff; i++) begin
                tmp = vals[i];
                for (j = i - 1; j >= 0 && vals[j] > tmp; j--)
                    vals[j+1] = vals[j];
                vals[j+1] = tmp;
            end
            // duplicate one count to get equal adjacent entries
            if (n_eff > 1 && $urandom_range(3) == 0) begin
                k       = $urandom_range(n_eff - 1, 1);
                vals[k] = vals[k-1];
            end
            if ($urandom_range(9) == 0)
                vals[0] = -32768;
            if ($urandom_range(9) == 0)
                vals[n_eff-1] = 32767;
        end
        for (i = 0; i < n_eff; i++)
            push_load(i, vals[i], rand_temp());
    endtask

    // Driver: present the next pending command, hold it until accepted, then
    // advance after a random idle gap. start gets at most one assignment per edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start     <= 1'b0;
            idle_left  = 0;
        end else begin
            if (start && !busy) begin
                // transaction accepted at this edge: update the bench table or
                // queue the expected temperature
                if (cur_cmd.mode == MODE_LOAD) begin
                    cal_count[cur_cmd.index] = cur_cmd.count;
                    cal_temp[cur_cmd.index]  = cur_cmd.temp;
                end else begin
                    expected_temps.push_back(interpolate_temp(cur_cmd.sample));
                end
                gap_roll = $urandom_range(99);
                if (no_idle || gap_roll < 60)
                    idle_left = 0;
                else if (gap_roll < 92)
                    idle_left = $urandom_range(3, 1);
                else
                    idle_left = $urandom_range(60, 10);
            end
            // a command still waiting on busy stays on the ports untouched
            if (!(start && busy)) begin
                if (idle_left > 0) begin
                    idle_left--;
                    start <= 1'b0;
                end else if (pending_cmds.size() != 0) begin
                    cur_cmd        = pending_cmds.pop_front();
                    start         <= 1'b1;
                    i_mode        <= cur_cmd.mode;
                    i_entry_index <= cur_cmd.index;
                    i_entry_count <= cur_cmd.count;
                    i_entry_temp  <= cur_cmd.temp;
                    i_sample      <= cur_cmd.sample;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: results cannot be held off, so take every strobe and check it
    // against the oldest expected temperature
    always @(posedge i_clk) begin
        t_temp_result want;
        if (i_rst_n && o_strobe) begin
            if (expected_temps.size() == 0) begin
                $error("result strobe with no conversion pending: temperature %0d valid %0d",
                       o_temperature, o_valid_res);
                fail_count++;
            end else begin
                want = expected_temps.pop_front();
                if (o_temperature !== want.temperature) begin
                    $error("temperature: expected %0d, actual %0d",
                           want.temperature, o_temperature);
                    fail_count++;
                end
                if (o_valid_res !== want.valid_res) begin
                    $error("valid_res: expected %0d, actual %0d",
                           want.valid_res, o_valid_res);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: drop the run if it stops making progress
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int phase_sizes [13] = '{2, 256, 3, 511, 1, 9, 0, 17, 130, 5, 64, 2, 33};
        int n, n_eff, p, j;
        bit need_fill;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: table with both count extremes, a zero and a full-scale
        // temperature, equal adjacent counts and a falling segment
        set_entries(0);
        push_load(0, -32768, 0);
        push_load(1, -1000, 38400);
        push_load(2, -1000, 65535);
        push_load(3, 500, 32000);
        push_load(4, 32767, 65535);
        // empty table: every sample is invalid
        push_convert(0);
        push_convert(-32768);

        set_entries(5);
        push_convert(-32768);      // equal to the first count
        push_convert(-32767);      // just inside the first segment
        push_convert(-1000);       // exactly on an entry
        push_convert(-999);        // past the duplicate pair, falling segment
        push_convert(0);
        push_convert(499);
        push_convert(500);
        push_convert(32766);
        push_convert(32767);       // exactly on the last entry

        set_entries(4);
        push_convert(32767);       // above the last used count
        push_convert(501);

        set_entries(1);
        push_load(0, 100, 65535);
        push_convert(99);          // below the first count
        push_convert(100);
        push_convert(101);

        // Random phases: reload the table if needed (mostly sorted), then mix conversions
        // with noise loads. Oversized settings fold onto the full depth.
        for (p = 0; p < 15; p++) begin
            n = (p < 13) ? phase_sizes[p] : $urandom_range(48, 2);
            set_entries(n);
            n_eff   = (n > TABLE_DEPTH) ? TABLE_DEPTH : n;
            no_idle = ($urandom_range(3) == 0);
            need_fill = (n_eff > 0 && n_eff <= 40);
            for (j = 0; j < n_eff; j++)
                if (!plan_written[j])
                    need_fill = 1'b1;
            if (need_fill)
                build_table(n_eff, $urandom_range(9) != 0);
            for (j = 0; j < 15; j++) begin
                // pause mid-phase until the block is fully drained
                if (j == 12)
                    wait_drain();
                if ($urandom_range(99) < 15)
                    push_load($urandom_range(TABLE_DEPTH - 1), rand_count(), rand_temp());
                else
                    push_convert(pick_sample(n_eff));
            end
        end

        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_temps.size() != 0) begin
            $error("%0d expected results never arrived", expected_temps.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ count_to_temperature_lut_interp_top.f @@
hw/rtl/cti_pkg.sv
hw/rtl/cti_muldiv.sv
hw/rtl/count_to_temperature_lut_interp_top.sv
dv/tb.sv
